>>> rtl/mrd_pkg.sv
package mrd_pkg;

    // Sizes of the opaque identifier fields, in bytes
    localparam int REPLICA_BYTES = 16;
    localparam int SEGMENT_BYTES = 16;
    localparam int MODEL_BYTES   = 16;

    localparam logic [7:0] ENCODING_VERSION = 8'd1;

    // Byte offsets of the record layout
    localparam int OFF_VER  = 0;
    localparam int OFF_KIND = 1;
    localparam int OFF_CTR  = 2;
    localparam int OFF_REP  = OFF_CTR + 8;
    localparam int OFF_PREV = OFF_REP + REPLICA_BYTES;
    localparam int OFF_SEG  = OFF_PREV + 8;
    localparam int OFF_CNT  = OFF_SEG + SEGMENT_BYTES;
    localparam int OFF_TOT  = OFF_CNT + 4;
    localparam int OFF_MOD  = OFF_TOT + 8;
    localparam int OFF_SLOT = OFF_MOD + MODEL_BYTES;
    localparam int OFF_SUCC = OFF_SLOT + 4;
    localparam int REC_LEN  = OFF_SUCC + SEGMENT_BYTES;

    // Position counter holds 0 .. REC_LEN
    localparam int POS_W = $clog2(REC_LEN + 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_KIND_FIRST = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KIND_LAST  = 8'd1;

    localparam logic [7:0] KIND_FIRST_RST = 8'd0;
    localparam logic [7:0] KIND_LAST_RST  = 8'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        record_ok;
        logic [7:0]  op_kind;
        logic [63:0] op_counter;
        logic [63:0] op_prev;
        logic [31:0] vector_count;
        logic [63:0] byte_total;
        logic [31:0] slot_index;
    } t_out_item;

endpackage

>>> rtl/mrd_accum.sv
module mrd_accum
    import mrd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  t_in_item   i_item,
    input  logic [7:0] i_kind_first,
    input  logic [7:0] i_kind_last,
    output t_out_item  o_result
);

    logic [POS_W-1:0] r_pos,     n_pos;
    logic             r_failed,  n_failed;
    logic [7:0]       r_kind,    n_kind;
    logic [63:0]      r_counter, n_counter;
    logic [63:0]      r_prev,    n_prev;
    logic [31:0]      r_count,   n_count;
    logic [63:0]      r_total,   n_total;
    logic [31:0]      r_slot,    n_slot;

    logic [7:0] b;
    logic       exact;

    function automatic logic in_field(input logic [POS_W-1:0] p, input int off, input int len);
        in_field = (p >= POS_W'(off)) && (p < POS_W'(off + len));
    endfunction

    always_comb begin
        b         = i_item.data_byte;
        n_pos     = r_pos;
        n_failed  = r_failed;
        n_kind    = r_kind;
        n_counter = r_counter;
        n_prev    = r_prev;
        n_count   = r_count;
        n_total   = r_total;
        n_slot    = r_slot;

        if (r_pos >= POS_W'(REC_LEN)) begin
            // past the end: hold position, mark the record bad
            n_failed = 1'b1;
        end else begin
            n_pos = r_pos + 1'b1;
            if (r_pos == POS_W'(OFF_VER)) begin
                if (b != ENCODING_VERSION) n_failed = 1'b1;
            end else if (r_pos == POS_W'(OFF_KIND)) begin
                n_kind = b;
                if (b < i_kind_first || b > i_kind_last) n_failed = 1'b1;
            end else if (in_field(r_pos, OFF_CTR, 8)) begin
                n_counter = {r_counter[55:0], b};
            end else if (in_field(r_pos, OFF_PREV, 8)) begin
                n_prev = {r_prev[55:0], b};
                if (r_pos == POS_W'(OFF_PREV + 7) && n_prev >= r_counter) n_failed = 1'b1;
            end else if (in_field(r_pos, OFF_CNT, 4)) begin
                n_count = {r_count[23:0], b};
            end else if (in_field(r_pos, OFF_TOT, 8)) begin
                n_total = {r_total[55:0], b};
            end else if (in_field(r_pos, OFF_SLOT, 4)) begin
                n_slot = {r_slot[23:0], b};
            end
        end

        exact = (r_pos == POS_W'(REC_LEN - 1));

        o_result.record_ok    = !n_failed && exact;
        o_result.op_kind      = n_kind;
        o_result.op_counter   = n_counter;
        o_result.op_prev      = n_prev;
        o_result.vector_count = n_count;
        o_result.byte_total   = n_total;
        o_result.slot_index   = n_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_failed  <= 1'b0;
            r_kind    <= '0;
            r_counter <= '0;
            r_prev    <= '0;
            r_count   <= '0;
            r_total   <= '0;
            r_slot    <= '0;
        end else if (i_take) begin
            if (i_item.last_byte) begin
                // record done: start the next one from zero
                r_pos     <= '0;
                r_failed  <= 1'b0;
                r_kind    <= '0;
                r_counter <= '0;
                r_prev    <= '0;
                r_count   <= '0;
                r_total   <= '0;
                r_slot    <= '0;
            end else begin
                r_pos     <= n_pos;
                r_failed  <= n_failed;
                r_kind    <= n_kind;
                r_counter <= n_counter;
                r_prev    <= n_prev;
                r_count   <= n_count;
                r_total   <= n_total;
                r_slot    <= n_slot;
            end
        end
    end

endmodule

>>> rtl/manifest_record_decoder.sv
// Manifest record decoder: takes one record byte per request, the last byte
// flagged, and on the last byte returns one result with the gathered counter,
// back-pointer, vector count, byte total, slot index, kind and an ok bit (version
// is 1, kind lies within kind_first..kind_last, back-pointer below counter, length
// exactly 98 bytes with 16-byte identifiers). A byte is taken every cycle unless
// the input stalls: it is registered at the input, then folded from that register
// into the record state and, if last, its result is written into the output
// register at that fold. The input stalls only on a last byte whose result cannot
// enter a still-full output register. Bytes beyond the record length are dropped
// and mark the record bad. Configuration writes are always taken (ready tied high)
// and must be made between records; indexes other than 0 and 1 are ignored.
module manifest_record_decoder
    import mrd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    logic       r_in_valid, n_in_valid;
    t_in_item   r_in;
    logic       r_out_valid, n_out_valid;
    t_out_item  r_out;
    logic [7:0] r_kind_first;
    logic [7:0] r_kind_last;

    logic      out_free;
    logic      advance;
    t_out_item result;

    mrd_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (advance),
        .i_item       (r_in),
        .i_kind_first (r_kind_first),
        .i_kind_last  (r_kind_last),
        .o_result     (result)
    );

    always_comb begin
        out_free    = !r_out_valid || i_out_ready;
        // a last byte waits until the output register can take its result
        advance     = r_in_valid && (!r_in.last_byte || out_free);
        o_in_ready  = !r_in_valid || advance;
        n_in_valid  = (i_in_valid && o_in_ready) || (r_in_valid && !advance);
        n_out_valid = (advance && r_in.last_byte) || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (advance && r_in.last_byte) begin
            r_out <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind_first <= KIND_FIRST_RST;
            r_kind_last  <= KIND_LAST_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KIND_FIRST: r_kind_first <= i_cfg_data;
                CFG_KIND_LAST:  r_kind_last  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> rtl/mrd_checker.sv
module mrd_checker
    import mrd_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input t_in_item             i_in_data,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input t_out_item            o_out_data
);

    // hold a stalled request
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("request changed or dropped while stalled");

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed or dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    a_ok_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.record_ok |-> o_out_data.op_prev < o_out_data.op_counter)
        else $error("good record with back-pointer not below counter");

    // input never stalls while the output side is empty
    a_in_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

endmodule

bind manifest_record_decoder mrd_checker u_mrd_checker (.*);

>>> dv/manifest_record_decoder_tb.sv
module manifest_record_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mrd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int ITEM_GOAL      = 1650;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    t_in_item             in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_item            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data  = '0;

    // Decoder state as predicted by the testbench
    logic [7:0]  kind_lo   = KIND_FIRST_RST;
    logic [7:0]  kind_hi   = KIND_LAST_RST;
    int          rec_pos   = 0;
    logic        rec_bad   = 1'b0;
    logic [7:0]  kind_seen = '0;
    logic [63:0] ctr_sh    = '0;
    logic [63:0] prev_sh   = '0;
    logic [31:0] vcnt_sh   = '0;
    logic [63:0] total_sh  = '0;
    logic [31:0] slot_sh   = '0;

    t_out_item   records_due[$];
    logic [7:0]  rec_buf[$];

    int n_bytes      = 0;
    int n_mismatch   = 0;
    int tx_gap_max   = 10;
    int rx_stall_max = 10;
    int rx_hold      = 0;

    manifest_record_decoder u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // Fold one accepted byte into the predicted record; queue the result on the last byte
    function automatic void decode_byte(input logic [7:0] b, input logic last);
        int        p;
        t_out_item r;
        p = rec_pos;
        if (p >= REC_LEN) begin
            rec_bad = 1'b1;
        end else begin
            if (p == OFF_VER) begin
                if (b != ENCODING_VERSION) rec_bad = 1'b1;
            end else if (p == OFF_KIND) begin
                kind_seen = b;
                if (b < kind_lo || b > kind_hi) rec_bad = 1'b1;
            end else if (p >= OFF_CTR && p < OFF_CTR + 8) begin
                ctr_sh = {ctr_sh[55:0], b};
            end else if (p >= OFF_PREV && p < OFF_PREV + 8) begin
                prev_sh = {prev_sh[55:0], b};
                // back-pointer must end up strictly below the counter
                if (p == OFF_PREV + 7 && prev_sh >= ctr_sh) rec_bad = 1'b1;
            end else if (p >= OFF_CNT && p < OFF_CNT + 4) begin
                vcnt_sh = {vcnt_sh[23:0], b};
            end else if (p >= OFF_TOT && p < OFF_TOT + 8) begin
                total_sh = {total_sh[55:0], b};
            end else if (p >= OFF_SLOT && p < OFF_SLOT + 4) begin
                slot_sh = {slot_sh[23:0], b};
            end
            rec_pos = p + 1;
        end
        if (last) begin
            r.record_ok    = !rec_bad && (p == REC_LEN - 1);
            r.op_kind      = kind_seen;
            r.op_counter   = ctr_sh;
            r.op_prev      = prev_sh;
            r.vector_count = vcnt_sh;
            r.byte_total   = total_sh;
            r.slot_index   = slot_sh;
            records_due.insert(records_due.size(), r);
            rec_pos   = 0;
            rec_bad   = 1'b0;
            kind_seen = '0;
            ctr_sh    = '0;
            prev_sh   = '0;
            vcnt_sh   = '0;
            total_sh  = '0;
            slot_sh   = '0;
        end
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] got,
                                          input logic [63:0] want);
        if (got !== want) begin
            n_mismatch++;
            if (n_mismatch <= 10)
                $display("%s: expected %0h, got %0h", name, want, got);
        end
    endfunction

    function automatic void check_record(input t_out_item got);
        t_out_item want;
        if (records_due.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= 10)
                $display("result with none expected: %0h", got);
            return;
        end
        want = records_due.pop_front();
        compare_field("record_ok", got.record_ok, want.record_ok);
        compare_field("op_kind", got.op_kind, want.op_kind);
        compare_field("op_counter", got.op_counter, want.op_counter);
        compare_field("op_prev", got.op_prev, want.op_prev);
        compare_field("vector_count", got.vector_count, want.vector_count);
        compare_field("byte_total", got.byte_total, want.byte_total);
        compare_field("slot_index", got.slot_index, want.slot_index);
    endfunction

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic void append_byte(input logic [7:0] v);
        rec_buf.insert(rec_buf.size(), v);
    endfunction

    function automatic void push_be(input logic [63:0] v, input int n);
        for (int i = n - 1; i >= 0; i--) append_byte(v[i*8 +: 8]);
    endfunction

    function automatic void push_noise(input int n);
        for (int i = 0; i < n; i++) append_byte(8'($urandom_range(0, 255)));
    endfunction

    function automatic void trim_to(input int n);
        while (rec_buf.size() > n) void'(rec_buf.pop_back());
    endfunction

    function automatic void build_record(input logic [7:0] ver, input logic [7:0] kind,
                                         input logic [63:0] ctr, input logic [63:0] prev,
                                         input logic [31:0] cnt, input logic [63:0] tot,
                                         input logic [31:0] slot);
        rec_buf.delete();
        append_byte(ver);
        append_byte(kind);
        push_be(ctr, 8);
        push_noise(REPLICA_BYTES);
        push_be(prev, 8);
        push_noise(SEGMENT_BYTES);
        push_be(cnt, 4);
        push_be(tot, 8);
        push_noise(MODEL_BYTES);
        push_be(slot, 4);
        push_noise(SEGMENT_BYTES);
    endfunction

    // Well-formed record with random content under the current kind range
    function automatic void build_good_record();
        logic [63:0] c;
        logic [63:0] pv;
        logic [7:0]  k;
        c = rand_word();
        if (c == 0) c = 64'd1;
        pv = ($urandom_range(0, 3) == 0) ? c - 64'd1 : rand_word() % c;
        k = (kind_lo <= kind_hi) ? 8'($urandom_range(kind_lo, kind_hi))
                                 : 8'($urandom_range(0, 255));
        build_record(ENCODING_VERSION, k, c, pv, rand_word(), rand_word(), rand_word());
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{data_byte: b, last_byte: last};
        do @(posedge clk); while (!in_ready);
        n_bytes++;
        decode_byte(b, last);
    endtask

    task automatic send_buf();
        for (int i = 0; i < rec_buf.size(); i++)
            send_byte(rec_buf[i], i == rec_buf.size() - 1);
    endtask

    // Hold the input until every predicted result is out, then let the pipeline settle
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (records_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_KIND_FIRST) kind_lo = val;
        else if (idx == CFG_KIND_LAST) kind_hi = val;
        @(posedge clk);
    endtask

    task automatic write_bad_index();
        write_reg(CFG_IDX_W'($urandom_range(CFG_KIND_LAST + 1, 255)),
                  8'($urandom_range(0, 255)));
    endtask

    task automatic test_directed();
        tx_gap_max   = 3;
        rx_stall_max = 3;
        // smallest passing record: counter 1, back-pointer 0
        build_record(ENCODING_VERSION, 8'd0, 64'd1, 64'd0, '0, '0, '0);
        send_buf();
        build_record(ENCODING_VERSION, 8'd2, '1, 64'hFFFF_FFFF_FFFF_FFFE, '1, '1, '1);
        send_buf();
        // kind just above the reset range
        build_record(ENCODING_VERSION, 8'd3, 64'd10, 64'd9, 32'd5, 64'd6, 32'd7);
        send_buf();
        build_record(8'd0, 8'd1, 64'd10, 64'd9, 32'd5, 64'd6, 32'd7);
        send_buf();
        // back-pointer equal to counter
        build_record(ENCODING_VERSION, 8'd1, 64'h0123_4567_89AB_CDEF,
                     64'h0123_4567_89AB_CDEF, '1, '0, '1);
        send_buf();
        // short records: one byte, one byte short
        build_good_record();
        trim_to(1);
        send_buf();
        build_good_record();
        trim_to(REC_LEN - 1);
        send_buf();
        // long records back to back with no idling: one byte over, and well past
        // where the position saturates
        tx_gap_max   = 0;
        rx_stall_max = 0;
        build_good_record();
        push_noise(1);
        send_buf();
        build_good_record();
        push_noise(40);
        send_buf();
        wait_drain();
    endtask

    // One probe per range setting, walking below, at the low end, at the high end and above
    task automatic test_kind_range();
        logic [7:0] lo_tab [5] = '{8'd0, 8'd255, 8'd0, 8'd200, 8'd77};
        logic [7:0] hi_tab [5] = '{8'd255, 8'd255, 8'd0, 8'd100, 8'd77};
        logic [7:0] probe [4];
        tx_gap_max   = 10;
        rx_stall_max = 10;
        for (int s = 0; s < 5; s++) begin
            wait_drain();
            write_reg(CFG_KIND_FIRST, lo_tab[s]);
            write_reg(CFG_KIND_LAST, hi_tab[s]);
            write_bad_index();
            probe = '{lo_tab[s] - 8'd1, lo_tab[s], hi_tab[s], hi_tab[s] + 8'd1};
            build_good_record();
            rec_buf[OFF_KIND] = probe[s % 4];
            send_buf();
        end
        wait_drain();
    endtask

    // Receiver holds off while short records keep coming, so the input stalls
    task automatic test_backpressure();
        wait_drain();
        tx_gap_max   = 0;
        rx_stall_max = 0;
        rx_hold      = RX_HOLD_CYCLES;
        repeat (30) begin
            rec_buf.delete();
            append_byte(ENCODING_VERSION);
            push_noise($urandom_range(0, 3));
            send_buf();
        end
        wait_drain();
    endtask

    task automatic test_random();
        int mix;
        int lo_i;
        int hi_i;
        while (n_bytes < ITEM_GOAL) begin
            wait_drain();
            if ($urandom_range(0, 1) == 1) begin
                case ($urandom_range(0, 4))
                    0: begin
                        write_reg(CFG_KIND_FIRST, KIND_FIRST_RST);
                        write_reg(CFG_KIND_LAST, KIND_LAST_RST);
                    end
                    1: begin
                        write_reg(CFG_KIND_FIRST, 8'd0);
                        write_reg(CFG_KIND_LAST, 8'd255);
                    end
                    2: begin
                        lo_i = $urandom_range(0, 255);
                        write_reg(CFG_KIND_FIRST, 8'(lo_i));
                        write_reg(CFG_KIND_LAST, 8'($urandom_range(lo_i, 255)));
                    end
                    3: begin
                        write_reg(CFG_KIND_FIRST, 8'($urandom_range(0, 255)));
                        write_reg(CFG_KIND_LAST, 8'($urandom_range(0, 255)));
                    end
                    default: begin
                        lo_i = $urandom_range(0, 255);
                        write_reg(CFG_KIND_FIRST, 8'(lo_i));
                        write_reg(CFG_KIND_LAST, 8'(lo_i));
                    end
                endcase
                if ($urandom_range(0, 3) == 0) write_bad_index();
            end
            tx_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 10;
            rx_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
            repeat ($urandom_range(1, 6)) begin
                mix = $urandom_range(0, 99);
                build_good_record();
                if (mix >= 60 && mix < 75) begin
                    // break exactly one check
                    lo_i = kind_lo;
                    hi_i = kind_hi;
                    case ($urandom_range(0, 2))
                        0: rec_buf[OFF_VER] = ($urandom_range(0, 1) == 1) ? 8'd0 : 8'hFF;
                        1: begin
                            if (hi_i < 255)
                                rec_buf[OFF_KIND] = 8'($urandom_range(hi_i + 1, 255));
                            else if (lo_i > 0)
                                rec_buf[OFF_KIND] = 8'($urandom_range(0, lo_i - 1));
                            else
                                rec_buf[OFF_VER] = 8'd0;
                        end
                        default: begin
                            for (int i = 0; i < 8; i++)
                                rec_buf[OFF_PREV + i] = rec_buf[OFF_CTR + i];
                        end
                    endcase
                end else if (mix >= 75 && mix < 87) begin
                    trim_to(($urandom_range(0, 3) == 0) ? $urandom_range(1, REC_LEN - 1)
                                                        : $urandom_range(1, 12));
                end else if (mix >= 87 && mix < 95) begin
                    push_noise($urandom_range(1, 40));
                end else if (mix >= 95) begin
                    rec_buf.delete();
                    push_noise($urandom_range(1, 20));
                end
                send_buf();
            end
        end
        wait_drain();
    endtask

    // Receiver: random stall before each result, or a long hold when one is requested
    initial begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever begin
            stall = $urandom_range(0, rx_stall_max);
            if (rx_hold > 0) begin
                stall   = rx_hold;
                rx_hold = 0;
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            check_record(out_data);
        end
    end

    // End the run when nothing moves on any channel for too long
    initial begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("manifest_record_decoder: mismatch");
        $finish;
    end

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_kind_range();
        test_backpressure();
        test_random();
        wait_drain();
        repeat (8) @(posedge clk);
        if (n_mismatch == 0 && records_due.size() == 0)
            $display("manifest_record_decoder: match");
        else
            $display("manifest_record_decoder: mismatch");
        $finish;
    end

endmodule

>>> manifest_record_decoder.f
rtl/mrd_pkg.sv
rtl/mrd_accum.sv
rtl/manifest_record_decoder.sv
rtl/mrd_checker.sv
dv/manifest_record_decoder_tb.sv
